// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, types and operation codes of the lfu cache policy block.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int OCC_W   = 5;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [DATA_W-1:0] data_type;
   typedef logic [OCC_W-1:0]  occ_out_type;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

endpackage

// ===== rtl/lfu_if.sv =====
// ----------------------------------------------------------------------------
// lfu_if
// Request and response channels of the lfu cache policy block.
// ----------------------------------------------------------------------------
interface lfu_req_if import lfu_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     op;
   key_type  key;
   data_type data_in;

   modport source (output valid, output op, output key, output data_in, input ready);
   modport sink   (input valid, input op, input key, input data_in, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        hit;
   data_type    data_out;
   logic        evicted;
   key_type     evicted_key;
   occ_out_type occupancy;

   modport source (output valid, output hit, output data_out, output evicted,
                   output evicted_key, output occupancy, input ready);
   modport sink   (input valid, input hit, input data_out, input evicted,
                   input evicted_key, input occupancy, output ready);
endinterface

// ===== rtl/lfu_lookup.sv =====
// ----------------------------------------------------------------------------
// lfu_lookup
// Parallel key match over all entries and lowest free entry search.
// ----------------------------------------------------------------------------
module lfu_lookup import lfu_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic [CAPACITY-1:0]         entry_valid,
   input  key_type                     entry_key [CAPACITY],
   input  key_type                     key,
   output logic                        hit,
   output logic [CAPACITY-1:0]         hit_onehot,
   output logic [$clog2(CAPACITY)-1:0] hit_idx,
   output logic [CAPACITY-1:0]         free_onehot,
   output logic [$clog2(CAPACITY)-1:0] free_idx
);

   localparam int IW = $clog2(CAPACITY);

   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] free_vec;

   function automatic logic [IW-1:0] encode(input logic [CAPACITY-1:0] oh);
      logic [IW-1:0] idx;
      idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (oh[i]) begin
            idx = idx | IW'(i);
         end
      end
      return idx;
   endfunction

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = entry_valid[i] && (entry_key[i] == key);
      end
   end

   // keys are unique, so at most one bit of match is set
   assign hit         = |match;
   assign hit_onehot  = match;
   assign hit_idx     = encode(match);

   // isolate the lowest clear valid bit
   assign free_vec    = ~entry_valid;
   assign free_onehot = free_vec & (~free_vec + CAPACITY'(1));
   assign free_idx    = encode(free_onehot);

endmodule

// ===== rtl/lfu_victim_tree.sv =====
// ----------------------------------------------------------------------------
// lfu_victim_tree
// Minimum tree over use count then recency rank, picks the eviction victim.
// ----------------------------------------------------------------------------
module lfu_victim_tree import lfu_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic [CAPACITY-1:0]         entry_valid,
   input  logic [COUNT_WIDTH-1:0]      use_count [CAPACITY],
   input  logic [$clog2(CAPACITY)-1:0] rank      [CAPACITY],
   input  key_type                     entry_key [CAPACITY],
   output logic [$clog2(CAPACITY)-1:0] victim_idx,
   output logic [$clog2(CAPACITY)-1:0] victim_rank,
   output key_type                     victim_key
);

   localparam int IW     = $clog2(CAPACITY);
   localparam int LEAVES = 1 << IW;
   localparam int NODES  = 2 * LEAVES - 1;
   localparam int CMPW   = COUNT_WIDTH + IW;

   logic            node_v   [NODES];
   logic [CMPW-1:0] node_c   [NODES];
   logic [IW-1:0]   node_i   [NODES];
   key_type         node_key [NODES];

   genvar g;
   generate
      for (g = 0; g < LEAVES; g++) begin : g_leaf
         if (g < CAPACITY) begin : g_used
            assign node_v[LEAVES-1+g]   = entry_valid[g];
            assign node_c[LEAVES-1+g]   = {use_count[g], rank[g]};
            assign node_i[LEAVES-1+g]   = IW'(g);
            assign node_key[LEAVES-1+g] = entry_key[g];
         end else begin : g_pad
            assign node_v[LEAVES-1+g]   = 1'b0;
            assign node_c[LEAVES-1+g]   = '0;
            assign node_i[LEAVES-1+g]   = '0;
            assign node_key[LEAVES-1+g] = '0;
         end
      end
      for (g = 0; g < LEAVES - 1; g++) begin : g_node
         logic take_left;
         // ranks are unique among valid entries, so ties cannot occur
         assign take_left = node_v[2*g+1] &&
                            (!node_v[2*g+2] || (node_c[2*g+1] <= node_c[2*g+2]));
         assign node_v[g]   = node_v[2*g+1] || node_v[2*g+2];
         assign node_c[g]   = take_left ? node_c[2*g+1]   : node_c[2*g+2];
         assign node_i[g]   = take_left ? node_i[2*g+1]   : node_i[2*g+2];
         assign node_key[g] = take_left ? node_key[2*g+1] : node_key[2*g+2];
      end
   endgenerate

   assign victim_idx  = node_i[0];
   assign victim_rank = node_c[0][IW-1:0];
   assign victim_key  = node_key[0];

endmodule

// ===== rtl/lfu_cache_policy_core.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_policy_core
// Fully associative key/value cache with lfu replacement, lru tie break.
// A request moves from the request register to the response register once
// that is free or being taken. Throughput: one request per cycle while the
// response is not stalled, set by the single-pass match, victim tree and
// entry update between the request and response registers.
// Reset: synchronous, empties the cache; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lfu_cache_policy_core import lfu_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int COUNT_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   lfu_req_if.sink    req_ch,
   lfu_rsp_if.source  rsp_ch
);

   localparam int IW = $clog2(CAPACITY);
   localparam int OW = $clog2(CAPACITY + 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // request register
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_op_ff;
   key_type       s1_key_ff;
   data_type      s1_data_ff;

   // entry state
   logic [CAPACITY-1:0]    entry_valid_ff, entry_valid_in;
   key_type                entry_key_ff   [CAPACITY];
   key_type                entry_key_in   [CAPACITY];
   logic [COUNT_WIDTH-1:0] use_count_ff   [CAPACITY];
   logic [COUNT_WIDTH-1:0] use_count_in   [CAPACITY];
   logic [IW-1:0]          rank_ff        [CAPACITY];
   logic [IW-1:0]          rank_in        [CAPACITY];
   logic [OW-1:0]          occ_ff, occ_in;
   data_type               value_mem      [CAPACITY];
   data_type               value_rd_ff;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_hit_ff;
   logic          rsp_get_hit_ff;
   logic          rsp_evicted_ff;
   key_type       rsp_evicted_key_ff, rsp_evicted_key_in;
   occ_out_type   rsp_occ_ff;

   logic                advance;
   logic                hit;
   logic [CAPACITY-1:0] hit_onehot;
   logic [IW-1:0]       hit_idx;
   logic [CAPACITY-1:0] free_onehot;
   logic [IW-1:0]       free_idx;
   logic [IW-1:0]       victim_idx;
   logic [IW-1:0]       victim_rank;
   key_type             victim_key;

   logic                is_put;
   logic                full;
   logic                put_miss;
   logic                evict;
   logic                close_gap;
   logic [IW-1:0]       hit_rank;
   logic [IW-1:0]       gap_rank;
   logic [IW-1:0]       new_rank;
   logic [IW-1:0]       slot_idx;
   logic [CAPACITY-1:0] ins_onehot;

   lfu_lookup #(
      .CAPACITY (CAPACITY)
   ) u_lookup (
      .entry_valid (entry_valid_ff),
      .entry_key   (entry_key_ff),
      .key         (s1_key_ff),
      .hit         (hit),
      .hit_onehot  (hit_onehot),
      .hit_idx     (hit_idx),
      .free_onehot (free_onehot),
      .free_idx    (free_idx)
   );

   lfu_victim_tree #(
      .CAPACITY    (CAPACITY),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_victim (
      .entry_valid (entry_valid_ff),
      .use_count   (use_count_ff),
      .rank        (rank_ff),
      .entry_key   (entry_key_ff),
      .victim_idx  (victim_idx),
      .victim_rank (victim_rank),
      .victim_key  (victim_key)
   );

   // handshake
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_comb begin
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // decision for the request held in the request register
   assign is_put    = (s1_op_ff == OP_PUT);
   assign full      = (occ_ff == OW'(CAPACITY));
   assign put_miss  = !hit && is_put;
   assign evict     = put_miss && full;
   assign close_gap = hit || evict;

   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit_onehot[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
      end
   end

   assign gap_rank   = hit ? hit_rank : victim_rank;
   assign new_rank   = close_gap ? IW'(occ_ff - OW'(1)) : IW'(occ_ff);
   assign ins_onehot = full ? (CAPACITY'(1) << victim_idx) : free_onehot;
   assign slot_idx   = hit ? hit_idx : (full ? victim_idx : free_idx);

   always_comb begin
      entry_valid_in = entry_valid_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         entry_key_in[i] = entry_key_ff[i];
         use_count_in[i] = use_count_ff[i];
         rank_in[i]      = rank_ff[i];
         if (advance) begin
            if (put_miss && ins_onehot[i]) begin
               // the victim's slot is reused, so no gap closing for it
               entry_valid_in[i] = 1'b1;
               entry_key_in[i]   = s1_key_ff;
               use_count_in[i]   = COUNT_WIDTH'(1);
               rank_in[i]        = new_rank;
            end else if (hit && hit_onehot[i]) begin
               if (use_count_ff[i] != COUNT_MAX) begin
                  use_count_in[i] = use_count_ff[i] + COUNT_WIDTH'(1);
               end
               rank_in[i] = new_rank;
            end else if (close_gap && entry_valid_ff[i] && (rank_ff[i] > gap_rank)) begin
               rank_in[i] = rank_ff[i] - IW'(1);
            end
         end
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (advance && put_miss && !full) begin
         occ_in = occ_ff + OW'(1);
      end
   end

   // response
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_evicted_key_in = evict ? victim_key : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
         occ_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         entry_valid_ff <= entry_valid_in;
         occ_ff         <= occ_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_op_ff   <= req_ch.op;
         s1_key_ff  <= req_ch.key;
         s1_data_ff <= req_ch.data_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         entry_key_ff[i] <= entry_key_in[i];
         use_count_ff[i] <= use_count_in[i];
         rank_ff[i]      <= rank_in[i];
      end
      if (advance) begin
         rsp_hit_ff         <= hit;
         rsp_get_hit_ff     <= hit && !is_put;
         rsp_evicted_ff     <= evict;
         rsp_evicted_key_ff <= rsp_evicted_key_in;
         rsp_occ_ff         <= OCC_W'(occ_in);
      end
   end

   // value store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (advance && is_put) begin
         value_mem[slot_idx] <= s1_data_ff;
      end
      if (advance) begin
         value_rd_ff <= value_mem[hit_idx];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hit         = rsp_hit_ff;
   assign rsp_ch.data_out    = rsp_get_hit_ff ? value_rd_ff : '0;
   assign rsp_ch.evicted     = rsp_evicted_ff;
   assign rsp_ch.evicted_key = rsp_evicted_key_ff;
   assign rsp_ch.occupancy   = rsp_occ_ff;

`ifndef SYNTHESIS
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(entry_valid_ff) == 32'(occ_ff))
      else $error("occupancy count disagrees with valid bits");

   a_single_match: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0(hit_onehot))
      else $error("key present in more than one entry");

   a_evict_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (advance && evict) |=> (occ_ff == OW'(CAPACITY)) && rsp_evicted_ff && !rsp_hit_ff)
      else $error("eviction without a full cache or on a hit");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (advance && put_miss && !full) |=> (occ_ff == $past(occ_ff) + OW'(1)))
      else $error("insert did not raise occupancy");
`endif

endmodule
